>>> rtl/msgr_flow_classifier_unit_macros.svh
// Assertion macros for the messenger flow classifier.
// Uses the clk_i and rst_ni names of the module that includes it.
`ifndef MSGR_FLOW_CLASSIFIER_UNIT_MACROS_SVH
`define MSGR_FLOW_CLASSIFIER_UNIT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define MFC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mfc check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define MFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mfc check failed");

`endif

>>> rtl/mfc_pkg.sv
// Shared types and constants of the messenger flow classifier.
// No dependencies; used by every module of the block.
package mfc_pkg;

  localparam int unsigned MAX_PAYLOAD = 16384;
  localparam int unsigned POS_W = $clog2(MAX_PAYLOAD + 1);

  typedef logic [POS_W-1:0] pos_t;

  localparam logic [7:0] TAG_MSG = 8'h07;
  localparam logic [7:0] TAG_ACK = 8'h08;

  localparam int unsigned REC_LEN = 9;
  localparam int unsigned SEQ_FIRST = 1;
  localparam int unsigned SEQ_LAST = 8;
  localparam int unsigned LEN_FIRST = 23;
  localparam int unsigned LEN_LAST = 34;
  localparam int unsigned MSG_OVERHEAD = 75;
  localparam int unsigned MSG_MIN_REM = 54;

  localparam logic [7:0] BANNER [0:REC_LEN-1] = '{
    8'h63, 8'h65, 8'h70, 8'h68, 8'h20, 8'h76, 8'h30, 8'h32, 8'h37
  };

  localparam logic [1:0] VERDICT_NONE = 2'd0;
  localparam logic [1:0] VERDICT_DETECTED = 2'd1;
  localparam logic [1:0] VERDICT_EXCLUDED = 2'd2;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       end_of_packet;
    logic       is_tcp;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] verdict;
  } result_t;

endpackage

>>> rtl/mfc_in_reg.sv
// Input register stage of the messenger flow classifier.
// Depends on mfc_pkg for the request type.
module mfc_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mfc_pkg::item_t item_i,
  input  logic          adv_i,
  output logic          valid_o,
  output mfc_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  mfc_pkg::item_t item_q;
  logic           load;

  assign in_ready_o = !valid_q || adv_i;
  assign load = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o = item_q;

endmodule

>>> rtl/mfc_core.sv
// Per-flow parser state and packet verdict logic of the messenger flow classifier.
// Depends on mfc_pkg and on the assertion macros header.
`include "msgr_flow_classifier_unit_macros.svh"

module mfc_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  mfc_pkg::item_t   item_i,
  output mfc_pkg::result_t result_o
);

  typedef enum logic [3:0] {
    PH_TAG  = 4'b0001,
    PH_ACK  = 4'b0010,
    PH_MSG  = 4'b0100,
    PH_DONE = 4'b1000
  } phase_e;

  logic [1:0]        packets_seen_q, packets_seen_d;
  logic [7:0]        last_tag_q, last_tag_d;
  logic [63:0]       last_seq_q, last_seq_d;
  mfc_pkg::pos_t     byte_pos_q, byte_pos_d;
  mfc_pkg::pos_t     record_start_q, record_start_d;
  phase_e            phase_q, phase_d;
  logic [7:0]        record_tag_q, record_tag_d;
  logic [63:0]       field_accum_q, field_accum_d;
  logic [31:0]       msg_total_q, msg_total_d;
  logic              banner_match_q, banner_match_d;
  logic              hit_q, hit_d;

  logic [7:0]        b;
  mfc_pkg::pos_t     p;
  mfc_pkg::pos_t     k;
  mfc_pkg::pos_t     rem;
  logic [2:0]        lane;
  logic [1:0]        len_lane;
  logic              take;
  logic              bm;
  logic              hit_fin;
  logic [1:0]        verdict;

  assign b = item_i.payload_byte;
  assign p = byte_pos_q;
  assign k = byte_pos_q - record_start_q;
  assign lane = 3'(k - mfc_pkg::pos_t'(mfc_pkg::SEQ_FIRST));
  assign len_lane = 2'(k - mfc_pkg::pos_t'(mfc_pkg::LEN_FIRST));
  assign take = step_i && (byte_pos_q < mfc_pkg::pos_t'(mfc_pkg::MAX_PAYLOAD));

  always_comb begin
    packets_seen_d = packets_seen_q;
    last_tag_d = last_tag_q;
    last_seq_d = last_seq_q;
    byte_pos_d = byte_pos_q;
    record_start_d = record_start_q;
    phase_d = phase_q;
    record_tag_d = record_tag_q;
    field_accum_d = field_accum_q;
    msg_total_d = msg_total_q;
    banner_match_d = banner_match_q;
    hit_d = hit_q;
    bm = banner_match_q;
    hit_fin = 1'b0;
    rem = '0;
    verdict = mfc_pkg::VERDICT_NONE;

    if (take) begin
      if (p < mfc_pkg::pos_t'(mfc_pkg::REC_LEN)) begin
        bm = banner_match_q && (b == mfc_pkg::BANNER[p[3:0]]);
        banner_match_d = bm;
        if ((p == mfc_pkg::pos_t'(mfc_pkg::REC_LEN - 1)) && bm && (packets_seen_q <= 2'd1)) begin
          hit_d = 1'b1;
        end
      end

      unique case (phase_q)
        PH_TAG: begin
          record_tag_d = b;
          field_accum_d = '0;
          msg_total_d = 32'(mfc_pkg::MSG_OVERHEAD) + 32'(p);
          if (b == mfc_pkg::TAG_ACK) begin
            phase_d = PH_ACK;
          end else if (b == mfc_pkg::TAG_MSG) begin
            phase_d = PH_MSG;
          end else begin
            phase_d = PH_DONE;
          end
        end
        PH_ACK: begin
          if ((k >= mfc_pkg::pos_t'(mfc_pkg::SEQ_FIRST)) &&
              (k <= mfc_pkg::pos_t'(mfc_pkg::SEQ_LAST))) begin
            field_accum_d[{lane, 3'b000} +: 8] = b;
          end
          if (k == mfc_pkg::pos_t'(mfc_pkg::SEQ_LAST)) begin
            if ((last_tag_q == mfc_pkg::TAG_MSG) && ({b, field_accum_q[55:0]} == last_seq_q)) begin
              hit_d = 1'b1;
            end
            record_start_d = p + mfc_pkg::pos_t'(1);
            phase_d = PH_TAG;
            record_tag_d = '0;
          end
        end
        PH_MSG: begin
          if ((k >= mfc_pkg::pos_t'(mfc_pkg::SEQ_FIRST)) &&
              (k <= mfc_pkg::pos_t'(mfc_pkg::SEQ_LAST))) begin
            field_accum_d[{lane, 3'b000} +: 8] = b;
          end else if ((k >= mfc_pkg::pos_t'(mfc_pkg::LEN_FIRST)) &&
                       (k <= mfc_pkg::pos_t'(mfc_pkg::LEN_LAST))) begin
            msg_total_d = msg_total_q + (32'(b) << {len_lane, 3'b000});
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase

      byte_pos_d = p + mfc_pkg::pos_t'(1);
    end

    if (step_i && item_i.end_of_packet) begin
      rem = byte_pos_d - record_start_d;
      if (!item_i.is_tcp) begin
        verdict = mfc_pkg::VERDICT_EXCLUDED;
      end else if (byte_pos_d >= mfc_pkg::pos_t'(mfc_pkg::REC_LEN)) begin
        if (packets_seen_q != 2'd3) begin
          packets_seen_d = packets_seen_q + 2'd1;
        end
        hit_fin = hit_d;
        if ((phase_d == PH_MSG) && (rem > mfc_pkg::pos_t'(mfc_pkg::MSG_MIN_REM))) begin
          if (msg_total_d == 32'(byte_pos_d)) begin
            hit_fin = 1'b1;
          end
          last_seq_d = field_accum_d;
        end
        last_tag_d = record_tag_d;
        verdict = hit_fin ? mfc_pkg::VERDICT_DETECTED : mfc_pkg::VERDICT_NONE;
      end

      byte_pos_d = '0;
      record_start_d = '0;
      phase_d = PH_TAG;
      record_tag_d = '0;
      field_accum_d = '0;
      msg_total_d = '0;
      banner_match_d = 1'b1;
      hit_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      packets_seen_q <= '0;
      last_tag_q <= '0;
      last_seq_q <= '0;
      byte_pos_q <= '0;
      record_start_q <= '0;
      phase_q <= PH_TAG;
      record_tag_q <= '0;
      field_accum_q <= '0;
      msg_total_q <= '0;
      banner_match_q <= 1'b1;
      hit_q <= 1'b0;
    end else begin
      packets_seen_q <= packets_seen_d;
      last_tag_q <= last_tag_d;
      last_seq_q <= last_seq_d;
      byte_pos_q <= byte_pos_d;
      record_start_q <= record_start_d;
      phase_q <= phase_d;
      record_tag_q <= record_tag_d;
      field_accum_q <= field_accum_d;
      msg_total_q <= msg_total_d;
      banner_match_q <= banner_match_d;
      hit_q <= hit_d;
    end
  end

  assign result_o.valid = step_i && item_i.end_of_packet;
  assign result_o.verdict = verdict;

  `MFC_ASSERT(a_pos_bound, byte_pos_q <= mfc_pkg::pos_t'(mfc_pkg::MAX_PAYLOAD))
  `MFC_ASSERT(a_start_le_pos, record_start_q <= byte_pos_q)
  `MFC_ASSERT(a_ack_tag, (phase_q != PH_ACK) || (record_tag_q == mfc_pkg::TAG_ACK))
  `MFC_ASSERT_NEXT(a_seen_sat, packets_seen_q == 2'd3, packets_seen_q == 2'd3)
  `MFC_ASSERT_NEXT(a_eop_clear, step_i && item_i.end_of_packet, byte_pos_q == '0)

endmodule

>>> rtl/msgr_flow_classifier_unit.sv
// Messenger flow classifier: one payload byte per request, one verdict per packet end.
// A request is held in the input register, and its verdict is registered in the verdict register.
// Throughput: one byte per cycle; the input register and the verdict register stall
// together only when a verdict waits and out_ready_i is low.
// Reset: rst_ni is asynchronous and clears all flow and packet state at once.
// Depends on mfc_pkg, mfc_in_reg and mfc_core.
module msgr_flow_classifier_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] payload_byte_i,
  input  logic       end_of_packet_i,
  input  logic       is_tcp_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] verdict_o
);

  mfc_pkg::item_t   in_item;
  mfc_pkg::item_t   s1_item;
  mfc_pkg::result_t result;
  logic             s1_valid;
  logic             adv;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       verdict_q;

  assign in_item.payload_byte = payload_byte_i;
  assign in_item.end_of_packet = end_of_packet_i;
  assign in_item.is_tcp = is_tcp_i;

  assign adv = !out_valid_q || out_ready_i;

  mfc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .adv_i      (adv),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  mfc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_valid && adv),
    .item_i   (s1_item),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = result.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && result.valid) begin
      verdict_q <= result.verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o = verdict_q;

endmodule

>>> dv/tb_msgr_flow_classifier_unit.sv
// Testbench for the messenger flow classifier: drives payload bytes of whole packets and
// checks every verdict against a flow model kept inside the bench.
// Depends on mfc_pkg and msgr_flow_classifier_unit.
`timescale 1ns / 1ps

module tb_msgr_flow_classifier_unit;
  import mfc_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_BYTES = 1150;
  localparam int MIN_RANDOM_VERDICTS = 60;
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [1:0] {PH_TAG, PH_ACK, PH_MSG, PH_DONE} parse_phase_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] payload_byte_i = 8'h00;
  logic       end_of_packet_i = 1'b0;
  logic       is_tcp_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] verdict_o;

  msgr_flow_classifier_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .payload_byte_i (payload_byte_i),
    .end_of_packet_i(end_of_packet_i),
    .is_tcp_i       (is_tcp_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .verdict_o      (verdict_o)
  );

  always #10 clk_i = ~clk_i;

  // Flow state of the model.
  logic [1:0]   seen_cnt;
  logic [7:0]   prev_tag;
  logic [63:0]  prev_seq;
  int unsigned  pos;
  int unsigned  rec_start;
  parse_phase_e phase;
  logic [7:0]   rec_tag;
  logic [63:0]  seq_acc;
  logic [31:0]  len_acc;
  bit           banner_ok;
  bit           hit;

  logic [1:0] verdict_q[$];
  logic [7:0] pkt_bytes[$];
  logic [1:0] expected_verdict;

  int tx_calm;
  int rx_calm;
  int out_hold;
  int idle_cycles;
  int bytes_sent;
  int packets_sent;
  int verdicts_checked;
  int detected_cnt;
  int excluded_cnt;
  int mismatches;

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 60);
      return 0;
    end
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic void clear_packet_state();
    pos = 0;
    rec_start = 0;
    phase = PH_TAG;
    rec_tag = 8'h00;
    seq_acc = 64'h0;
    len_acc = 32'h0;
    banner_ok = 1'b1;
    hit = 1'b0;
  endfunction

  function automatic void reset_flow_state();
    seen_cnt = 2'd0;
    prev_tag = 8'h00;
    prev_seq = 64'h0;
    clear_packet_state();
  endfunction

  function automatic void absorb_byte(logic [7:0] b);
    logic [31:0] k;
    k = pos - rec_start;
    if (pos < REC_LEN) begin
      if (b != BANNER[pos]) banner_ok = 1'b0;
      if (pos == REC_LEN - 1 && banner_ok && seen_cnt <= 2'd1) hit = 1'b1;
    end
    case (phase)
      PH_TAG: begin
        rec_tag = b;
        seq_acc = 64'h0;
        len_acc = 32'h0;
        if (b == TAG_ACK) phase = PH_ACK;
        else if (b == TAG_MSG) phase = PH_MSG;
        else phase = PH_DONE;
      end
      PH_ACK: begin
        if (k >= SEQ_FIRST && k <= SEQ_LAST) seq_acc |= 64'(b) << (8 * (k - 1));
        if (k == SEQ_LAST) begin
          if (prev_tag == TAG_MSG && seq_acc == prev_seq) hit = 1'b1;
          rec_start = pos + 1;
          phase = PH_TAG;
          rec_tag = 8'h00;
        end
      end
      PH_MSG: begin
        if (k >= SEQ_FIRST && k <= SEQ_LAST) seq_acc |= 64'(b) << (8 * (k - 1));
        else if (k >= LEN_FIRST && k <= LEN_LAST)
          len_acc += 32'(b) << (8 * ((k - LEN_FIRST) % 4));
      end
      default: ;
    endcase
    pos++;
  endfunction

  function automatic bit predict_request(input logic [7:0] b, input logic eop,
                                         input logic tcp, output logic [1:0] v);
    logic [31:0] total;
    v = VERDICT_NONE;
    if (pos < MAX_PAYLOAD) absorb_byte(b);
    if (!eop) return 1'b0;
    if (!tcp) begin
      v = VERDICT_EXCLUDED;
    end else if (pos >= REC_LEN) begin
      if (seen_cnt < 2'd3) seen_cnt++;
      if (phase == PH_MSG && pos - rec_start > MSG_MIN_REM) begin
        total = MSG_OVERHEAD + len_acc + rec_start;
        if (total == pos) hit = 1'b1;
        prev_seq = seq_acc;
      end
      prev_tag = rec_tag;
      v = hit ? VERDICT_DETECTED : VERDICT_NONE;
    end
    clear_packet_state();
    return 1'b1;
  endfunction

  function automatic void add_noise(int n);
    repeat (n) pkt_bytes.push_back(8'($urandom));
  endfunction

  function automatic void push_le(logic [63:0] v, int n);
    for (int i = 0; i < n; i++) pkt_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void add_banner();
    for (int i = 0; i < REC_LEN; i++) pkt_bytes.push_back(BANNER[i]);
  endfunction

  function automatic void add_ack(logic [63:0] seq);
    pkt_bytes.push_back(TAG_ACK);
    push_le(seq, 8);
  endfunction

  // The three length fields sum to the record length plus skew, minus the fixed overhead.
  function automatic void add_message(logic [63:0] seq, int body_len, int skew);
    logic [31:0] target;
    logic [31:0] a;
    logic [31:0] b;
    target = 32'(body_len) + 32'(skew) - 32'(MSG_OVERHEAD);
    a = $urandom;
    b = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : 32'($urandom);
    pkt_bytes.push_back(TAG_MSG);
    push_le(seq, 8);
    add_noise(LEN_FIRST - SEQ_LAST - 1);
    push_le(a, 4);
    push_le(b, 4);
    push_le(target - a - b, 4);
    add_noise(body_len - (LEN_LAST + 1));
  endfunction

  function automatic int pick_skew();
    case ($urandom_range(0, 7))
      0: return 1;
      1: return -1;
      2: return int'($urandom);
      default: return 0;
    endcase
  endfunction

  function automatic logic [63:0] rand_seq();
    return {32'($urandom), 32'($urandom)};
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eop, input logic tcp);
    int gap;
    logic [1:0] v;
    gap = draw_wait(tx_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    payload_byte_i <= b;
    end_of_packet_i <= eop;
    is_tcp_i <= tcp;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    if (predict_request(b, eop, tcp, v)) begin
      verdict_q.push_back(v);
      packets_sent++;
    end
  endtask

  task automatic send_packet(input bit tcp);
    int last;
    last = pkt_bytes.size() - 1;
    for (int i = 0; i <= last; i++)
      send_byte(pkt_bytes[i], i == last, (i == last) ? tcp : 1'($urandom));
    pkt_bytes.delete();
  endtask

  task automatic wait_all_verdicts();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_short_and_foreign();
    for (int i = 0; i < REC_LEN - 1; i++) pkt_bytes.push_back(BANNER[i]);
    send_packet(1'b1);
    pkt_bytes.push_back(8'hFF);
    send_packet(1'b1);
    add_banner();
    send_packet(1'b0);
  endtask

  task automatic test_banner_window();
    add_banner();
    send_packet(1'b1);
    add_banner();
    add_noise(3);
    send_packet(1'b1);
    add_banner();
    send_packet(1'b1);
  endtask

  task automatic test_message_rules();
    add_message(64'hFFFF_FFFF_FFFF_FFFF, 55, 0);
    send_packet(1'b1);
    add_ack(prev_seq);
    add_message(64'h0, 60, 0);
    send_packet(1'b1);
    add_ack(prev_seq ^ 64'h1);
    send_packet(1'b1);
    add_message(rand_seq(), 58, 0);
    send_packet(1'b1);
    add_ack(prev_seq);
    add_ack(prev_seq);
    send_packet(1'b1);
    add_message(rand_seq(), 56, 0);
    send_packet(1'b1);
    add_ack(prev_seq);
    pkt_bytes.push_back(TAG_ACK);
    add_noise(3);
    send_packet(1'b1);
    add_message(rand_seq(), 57, 0);
    send_packet(1'b1);
    add_ack(rand_seq());
    pkt_bytes.push_back(8'h3C);
    add_noise(20);
    send_packet(1'b1);
    add_message(rand_seq(), 54, 0);
    send_packet(1'b1);
    add_ack(prev_seq);
    add_message(rand_seq(), 70, 1);
    send_packet(1'b1);
  endtask

  function automatic void build_random_packet(output bit tcp);
    int kind;
    int n;
    int choice;
    tcp = 1'b1;
    kind = $urandom_range(0, 99);
    if (kind < 50) begin
      n = $urandom_range(0, 3);
      repeat (n) add_ack(($urandom_range(0, 3) != 0) ? prev_seq : rand_seq());
      choice = $urandom_range(0, 5);
      if (choice == 0) begin
        pkt_bytes.push_back(8'($urandom_range(9, 255)));
        add_noise($urandom_range(0, 30));
      end else if (choice != 1 || n == 0) begin
        add_message(rand_seq(), $urandom_range(55, 90), pick_skew());
      end
    end else if (kind < 60) begin
      add_banner();
      if ($urandom_range(0, 2) == 0)
        pkt_bytes[$urandom_range(0, REC_LEN - 1)] ^= 8'(1 << $urandom_range(0, 7));
      add_noise($urandom_range(0, 20));
    end else if (kind < 70) begin
      n = $urandom_range(1, REC_LEN - 1);
      case ($urandom_range(0, 2))
        0: for (int i = 0; i < n; i++) pkt_bytes.push_back(BANNER[i]);
        1: begin
          pkt_bytes.push_back(TAG_ACK);
          add_noise(n - 1);
        end
        default: add_noise(n);
      endcase
    end else if (kind < 78) begin
      repeat ($urandom_range(0, 2)) add_ack(prev_seq);
      pkt_bytes.push_back(TAG_ACK);
      add_noise($urandom_range(0, 7));
    end else if (kind < 88) begin
      add_noise($urandom_range(REC_LEN, 40));
    end else begin
      tcp = 1'b0;
      if ($urandom_range(0, 1) == 0) add_message(rand_seq(), $urandom_range(55, 70), 0);
      else add_noise($urandom_range(1, 30));
    end
  endfunction

  task automatic test_random_flow();
    int start_bytes;
    int start_pkts;
    bit tcp;
    start_bytes = bytes_sent;
    start_pkts = packets_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES ||
           packets_sent - start_pkts < MIN_RANDOM_VERDICTS) begin
      build_random_packet(tcp);
      send_packet(tcp);
      if ($urandom_range(0, 24) == 0) wait_all_verdicts();
    end
  endtask

  always @(negedge clk_i) begin
    if (out_hold > 0) begin
      out_ready_i <= 1'b0;
      out_hold--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected verdict, expected none, actual %0d", $time, verdict_o);
        mismatches++;
      end else begin
        expected_verdict = verdict_q.pop_front();
        verdicts_checked++;
        if (verdict_o !== expected_verdict) begin
          $display("%0t: verdict mismatch, expected %0d, actual %0d",
                   $time, expected_verdict, verdict_o);
          mismatches++;
        end
        if (expected_verdict == VERDICT_DETECTED) detected_cnt++;
        if (expected_verdict == VERDICT_EXCLUDED) excluded_cnt++;
      end
      out_hold = draw_wait(rx_calm);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, no request moved for %0d cycles", $time, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    reset_flow_state();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_short_and_foreign();
    test_banner_window();
    test_message_rules();
    wait_all_verdicts();
    test_random_flow();
    wait_all_verdicts();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d payload bytes in %0d packets of banners, acks, messages and noise.",
             bytes_sent, packets_sent);
    $display("Checked %0d verdicts: %0d detected, %0d excluded, %0d mismatches.",
             verdicts_checked, detected_cnt, excluded_cnt, mismatches);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> msgr_flow_classifier_unit.f
+incdir+rtl
rtl/mfc_pkg.sv
rtl/mfc_in_reg.sv
rtl/mfc_core.sv
rtl/msgr_flow_classifier_unit.sv
dv/tb_msgr_flow_classifier_unit.sv
